// ===== src/qrs_pkg.sv =====
`default_nettype none

package qrs_pkg;

  // Register file
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned EPS_W = 31;
  localparam logic [EPS_W-1:0] EPS_RESET = 31'd107374;
  // Register index taken from paddr[2]
  localparam logic REG_NEAR_ZERO_LIMIT = 1'b0;

  // Number of roots reported with each result
  typedef enum logic [1:0] {
    ROOTS_NONE = 2'd0,
    ROOTS_ONE  = 2'd1,
    ROOTS_TWO  = 2'd2,
    ROOTS_ANY  = 2'd3
  } root_count_e;

endpackage

`default_nettype wire

// ===== src/qrs_if.sv =====
`default_nettype none

// Coefficient request channel
interface qrs_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] quad_coef;
  logic signed [31:0] lin_coef;
  logic signed [31:0] const_coef;

  modport source (output valid, quad_coef, lin_coef, const_coef, input ready);
  modport sink   (input valid, quad_coef, lin_coef, const_coef, output ready);
endinterface

// Root result channel
interface qrs_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         root_count;
  logic signed [31:0] first_root;
  logic signed [31:0] second_root;
  logic               root_saturated;

  modport source (output valid, root_count, first_root, second_root, root_saturated,
                  input ready);
  modport sink   (input valid, root_count, first_root, second_root, root_saturated,
                  output ready);
endinterface

`default_nettype wire

// ===== src/qrs_div.sv =====
`default_nettype none

// Pipelined restoring divider: one quotient bit per stage, lanes share a divisor.
// Each lane needs rem_i < div_i; feed_i holds the dividend bits shifted in.
module qrs_div #(
  parameter int LANES = 1,
  parameter int DW    = 32,
  parameter int QB    = 31,
  parameter int SBW   = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [DW-1:0]                   div_i,
  input  logic [LANES-1:0][DW-1:0]        rem_i,
  input  logic [LANES-1:0][QB-1:0]        feed_i,
  input  logic [SBW-1:0]                  side_i,
  output logic                            valid_o,
  output logic [LANES-1:0][QB-1:0]        quo_o,
  output logic [LANES-1:0]                rnd_o,
  output logic [SBW-1:0]                  side_o
);

  logic                     v_q    [QB];
  logic [DW-1:0]            d_q    [QB];
  logic [LANES-1:0][DW-1:0] r_q    [QB];
  logic [LANES-1:0][QB-1:0] f_q    [QB];
  logic [LANES-1:0][QB-1:0] q_q    [QB];
  logic [SBW-1:0]           s_q    [QB];

  logic                     v_in   [QB];
  logic [DW-1:0]            d_in   [QB];
  logic [LANES-1:0][DW-1:0] r_in   [QB];
  logic [LANES-1:0][QB-1:0] f_in   [QB];
  logic [LANES-1:0][QB-1:0] q_in   [QB];
  logic [SBW-1:0]           s_in   [QB];

  logic [LANES-1:0][DW:0]   trial  [QB];
  logic [LANES-1:0]         ge     [QB];
  logic [LANES-1:0][DW-1:0] r_d    [QB];
  logic [LANES-1:0][QB-1:0] f_d    [QB];
  logic [LANES-1:0][QB-1:0] q_d    [QB];

  // One trial subtraction per stage and lane
  always_comb begin
    for (int s = 0; s < QB; s++) begin
      if (s == 0) begin
        v_in[s] = valid_i;
        d_in[s] = div_i;
        r_in[s] = rem_i;
        f_in[s] = feed_i;
        q_in[s] = '0;
        s_in[s] = side_i;
      end else begin
        v_in[s] = v_q[s-1];
        d_in[s] = d_q[s-1];
        r_in[s] = r_q[s-1];
        f_in[s] = f_q[s-1];
        q_in[s] = q_q[s-1];
        s_in[s] = s_q[s-1];
      end
      for (int l = 0; l < LANES; l++) begin
        trial[s][l] = {r_in[s][l], f_in[s][l][QB-1]};
        ge[s][l]    = trial[s][l] >= {1'b0, d_in[s]};
        r_d[s][l]   = ge[s][l] ? DW'(trial[s][l] - {1'b0, d_in[s]}) : trial[s][l][DW-1:0];
        q_d[s][l]   = {q_in[s][l][QB-2:0], ge[s][l]};
        f_d[s][l]   = {f_in[s][l][QB-2:0], 1'b0};
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < QB; s++) v_q[s] <= 1'b0;
    end else if (en_i) begin
      for (int s = 0; s < QB; s++) v_q[s] <= v_in[s];
    end
  end

  // Advance partial remainders and quotients
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QB; s++) begin
        d_q[s] <= d_in[s];
        r_q[s] <= r_d[s];
        f_q[s] <= f_d[s];
        q_q[s] <= q_d[s];
        s_q[s] <= s_in[s];
      end
    end
  end

  // Round up when the remainder is at least half the divisor
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rnd_o[l] = {r_q[QB-1][l], 1'b0} >= {1'b0, d_q[QB-1]};
    end
  end

  assign valid_o = v_q[QB-1];
  assign quo_o   = q_q[QB-1];
  assign side_o  = s_q[QB-1];

endmodule

`default_nettype wire

// ===== src/qrs_sqrt.sv =====
`default_nettype none

// Pipelined integer square root: one root bit per stage, floor result.
module qrs_sqrt #(
  parameter int SW  = 32,
  parameter int SBW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*SW-1:0]   rad_i,
  input  logic [SBW-1:0]    side_i,
  output logic              valid_o,
  output logic [SW-1:0]     root_o,
  output logic [SBW-1:0]    side_o
);

  logic              v_q   [SW];
  logic [2*SW-1:0]   x_q   [SW];
  logic [SW+1:0]     r_q   [SW];
  logic [SW-1:0]     t_q   [SW];
  logic [SBW-1:0]    s_q   [SW];

  logic              v_in  [SW];
  logic [2*SW-1:0]   x_in  [SW];
  logic [SW+1:0]     r_in  [SW];
  logic [SW-1:0]     t_in  [SW];
  logic [SBW-1:0]    s_in  [SW];

  logic [SW+3:0]     trial [SW];
  logic [SW+3:0]     cand  [SW];
  logic              ge    [SW];
  logic [SW+1:0]     r_d   [SW];
  logic [SW-1:0]     t_d   [SW];
  logic [2*SW-1:0]   x_d   [SW];

  // Bring in two radicand bits and try root*4+1 in each stage
  always_comb begin
    for (int s = 0; s < SW; s++) begin
      if (s == 0) begin
        v_in[s] = valid_i;
        x_in[s] = rad_i;
        r_in[s] = '0;
        t_in[s] = '0;
        s_in[s] = side_i;
      end else begin
        v_in[s] = v_q[s-1];
        x_in[s] = x_q[s-1];
        r_in[s] = r_q[s-1];
        t_in[s] = t_q[s-1];
        s_in[s] = s_q[s-1];
      end
      trial[s] = {r_in[s], x_in[s][2*SW-1:2*SW-2]};
      cand[s]  = {2'b00, t_in[s], 2'b01};
      ge[s]    = trial[s] >= cand[s];
      r_d[s]   = ge[s] ? (SW+2)'(trial[s] - cand[s]) : trial[s][SW+1:0];
      t_d[s]   = {t_in[s][SW-2:0], ge[s]};
      x_d[s]   = {x_in[s][2*SW-3:0], 2'b00};
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SW; s++) v_q[s] <= 1'b0;
    end else if (en_i) begin
      for (int s = 0; s < SW; s++) v_q[s] <= v_in[s];
    end
  end

  // Advance partial roots
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < SW; s++) begin
        x_q[s] <= x_d[s];
        r_q[s] <= r_d[s];
        t_q[s] <= t_d[s];
        s_q[s] <= s_in[s];
      end
    end
  end

  assign valid_o = v_q[SW-1];
  assign root_o  = t_q[SW-1];
  assign side_o  = s_q[SW-1];

endmodule

`default_nettype wire

// ===== src/quadratic_root_solver_top.sv =====
`default_nettype none

// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Depth set by the normalizing divider, the square root and the 32-step root divider.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads near_zero_limit = 107374.
module quadratic_root_solver_top #(
  parameter int FRAC_BITS      = 16,
  parameter int NORM_FRAC_BITS = 30
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  qrs_req_if.sink                     req_i,
  qrs_res_if.source                   res_o,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [qrs_pkg::ADDR_W-1:0]  paddr_i,
  input  logic [31:0]                 pwdata_i,
  output logic [31:0]                 prdata_o,
  output logic                        pready_o
);

  localparam int NF  = NORM_FRAC_BITS;
  localparam int FB  = FRAC_BITS;
  localparam int NQB = NF + 1;
  localparam int NVW = NF + 2;
  localparam int PW  = 2 * NVW;
  localparam int SW  = NF + 2;
  localparam int SNW = NF + 3;
  localparam int RDW = NF + 2;
  localparam int NBW = RDW + FB;
  localparam int XW  = (NBW > 33) ? NBW : 33;
  localparam int TW  = XW - 32;
  localparam int CW  = (TW > RDW) ? TW : RDW;
  localparam int LW  = (PW > NF + 31) ? PW : NF + 31;

  typedef struct packed {
    logic sa;
    logic sb;
    logic sc;
    logic mzero;
  } norm_side_t;

  typedef struct packed {
    logic signed [NVW-1:0] an;
    logic signed [NVW-1:0] bn;
    logic signed [NVW-1:0] cn;
    logic                  lin;
    qrs_pkg::root_count_e  count;
  } sqrt_side_t;

  typedef struct packed {
    qrs_pkg::root_count_e count;
    logic [1:0]           neg;
    logic [1:0]           ovf;
  } div_side_t;

  function automatic logic [31:0] abs32(input logic signed [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [NVW-1:0] absn(input logic signed [NVW-1:0] x);
    return x[NVW-1] ? NVW'(-x) : NVW'(x);
  endfunction

  function automatic logic near_zero(input logic [NVW-1:0] mag,
                                     input logic [qrs_pkg::EPS_W-1:0] eps);
    return (mag == '0) || (qrs_pkg::EPS_W'(mag) < eps);
  endfunction

  logic en;
  logic out_v_q;

  // Whole pipeline moves when the output slot is free or being taken
  assign en          = !out_v_q || res_o.ready;
  assign req_i.ready = en;

  // ---------------------------------------------------------------- config
  logic [qrs_pkg::EPS_W-1:0] eps_q;
  logic                      reg_hit;

  assign reg_hit  = paddr_i[qrs_pkg::ADDR_W-1] == qrs_pkg::REG_NEAR_ZERO_LIMIT;
  assign pready_o = 1'b1;
  assign prdata_o = reg_hit ? {1'b0, eps_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= qrs_pkg::EPS_RESET;
    end else if (psel_i && penable_i && pwrite_i && reg_hit) begin
      eps_q <= pwdata_i[qrs_pkg::EPS_W-1:0];
    end
  end

  // ---------------------------------------------------------------- capture
  logic               va_q;
  logic signed [31:0] a_q, b_q, c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (en) va_q <= req_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= req_i.quad_coef;
      b_q <= req_i.lin_coef;
      c_q <= req_i.const_coef;
    end
  end

  // ---------------------------------------------------------------- magnitudes, max
  logic        vb_q;
  logic [31:0] ma_d, mb_d, mc_d, mab_d, m_d;
  logic [31:0] ma_q, mb_q, mc_q, m_q;
  norm_side_t  nsb_d, nsb_q;

  always_comb begin
    ma_d  = abs32(a_q);
    mb_d  = abs32(b_q);
    mc_d  = abs32(c_q);
    mab_d = (mb_d > ma_d) ? mb_d : ma_d;
    m_d   = (mc_d > mab_d) ? mc_d : mab_d;
    nsb_d.sa    = a_q[31];
    nsb_d.sb    = b_q[31];
    nsb_d.sc    = c_q[31];
    nsb_d.mzero = m_d == 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (en) vb_q <= va_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ma_q  <= ma_d;
      mb_q  <= mb_d;
      mc_q  <= mc_d;
      m_q   <= m_d;
      nsb_q <= nsb_d;
    end
  end

  // ---------------------------------------------------------------- normalize |x| / max
  logic [2:0][31:0]      nrem;
  logic [2:0][NQB-1:0]   nfeed;
  logic [2:0][NQB-1:0]   nquo;
  logic [2:0]            nrnd;
  logic                  nv;
  logic [$bits(norm_side_t)-1:0] nside_raw;
  norm_side_t            nside;

  always_comb begin
    nrem[0]  = {1'b0, ma_q[31:1]};
    nrem[1]  = {1'b0, mb_q[31:1]};
    nrem[2]  = {1'b0, mc_q[31:1]};
    nfeed[0] = NQB'(ma_q[0]) << NF;
    nfeed[1] = NQB'(mb_q[0]) << NF;
    nfeed[2] = NQB'(mc_q[0]) << NF;
  end

  qrs_div #(
    .LANES (3),
    .DW    (32),
    .QB    (NQB),
    .SBW   ($bits(norm_side_t))
  ) u_norm_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vb_q),
    .div_i   (m_q),
    .rem_i   (nrem),
    .feed_i  (nfeed),
    .side_i  (nsb_q),
    .valid_o (nv),
    .quo_o   (nquo),
    .rnd_o   (nrnd),
    .side_o  (nside_raw)
  );

  assign nside = nside_raw;

  // ---------------------------------------------------------------- round, restore sign
  logic                  v2_q, mz2_q;
  logic signed [NVW-1:0] an2_d, bn2_d, cn2_d, an2_q, bn2_q, cn2_q;
  logic [2:0][NQB-1:0]   nr;

  always_comb begin
    for (int l = 0; l < 3; l++) nr[l] = NQB'(nquo[l] + NQB'(nrnd[l]));
    an2_d = nside.sa ? -$signed(NVW'(nr[0])) : $signed(NVW'(nr[0]));
    bn2_d = nside.sb ? -$signed(NVW'(nr[1])) : $signed(NVW'(nr[1]));
    cn2_d = nside.sc ? -$signed(NVW'(nr[2])) : $signed(NVW'(nr[2]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= nv;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      an2_q <= an2_d;
      bn2_q <= bn2_d;
      cn2_q <= cn2_d;
      mz2_q <= nside.mzero;
    end
  end

  // ---------------------------------------------------------------- products, near-zero tests
  logic                  v3_q, mz3_q, nza3_q, nzb3_q, nzc3_q;
  logic signed [PW-1:0]  bb3_d, ac3_d, bb3_q, ac3_q;
  logic signed [NVW-1:0] an3_q, bn3_q, cn3_q;

  assign bb3_d = bn2_q * bn2_q;
  assign ac3_d = an2_q * cn2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bb3_q  <= bb3_d;
      ac3_q  <= ac3_d;
      an3_q  <= an2_q;
      bn3_q  <= bn2_q;
      cn3_q  <= cn2_q;
      mz3_q  <= mz2_q;
      nza3_q <= near_zero(absn(an2_q), eps_q);
      nzb3_q <= near_zero(absn(bn2_q), eps_q);
      nzc3_q <= near_zero(absn(cn2_q), eps_q);
    end
  end

  // ---------------------------------------------------------------- discriminant
  logic                  v4_q, mz4_q, nza4_q, nzb4_q, nzc4_q;
  logic signed [PW-1:0]  d4_q;
  logic signed [NVW-1:0] an4_q, bn4_q, cn4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d4_q   <= bb3_q - (ac3_q <<< 2);
      an4_q  <= an3_q;
      bn4_q  <= bn3_q;
      cn4_q  <= cn3_q;
      mz4_q  <= mz3_q;
      nza4_q <= nza3_q;
      nzb4_q <= nzb3_q;
      nzc4_q <= nzc3_q;
    end
  end

  // ---------------------------------------------------------------- classify
  logic                 v5_q;
  logic [PW-1:0]        magd5;
  logic                 dnz5;
  sqrt_side_t           ss5_d, ss5_q;
  logic [PW-1:0]        rad5_d, rad5_q;

  always_comb begin
    magd5        = d4_q[PW-1] ? PW'(-d4_q) : PW'(d4_q);
    dnz5         = (d4_q == '0) || (LW'(magd5) < (LW'(eps_q) << NF));
    ss5_d.an     = an4_q;
    ss5_d.bn     = bn4_q;
    ss5_d.cn     = cn4_q;
    ss5_d.lin    = nza4_q;
    ss5_d.count  = qrs_pkg::ROOTS_NONE;
    rad5_d       = '0;
    priority if (mz4_q) begin
      ss5_d.count = qrs_pkg::ROOTS_ANY;
    end else if (nza4_q) begin
      if (!nzb4_q)     ss5_d.count = qrs_pkg::ROOTS_ONE;
      else if (nzc4_q) ss5_d.count = qrs_pkg::ROOTS_ANY;
      else             ss5_d.count = qrs_pkg::ROOTS_NONE;
    end else if (dnz5) begin
      ss5_d.count = qrs_pkg::ROOTS_ONE;
    end else if (!d4_q[PW-1]) begin
      ss5_d.count = qrs_pkg::ROOTS_TWO;
      rad5_d      = PW'(d4_q);
    end else begin
      ss5_d.count = qrs_pkg::ROOTS_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ss5_q  <= ss5_d;
      rad5_q <= rad5_d;
    end
  end

  // ---------------------------------------------------------------- square root
  logic                           sv;
  logic [SW-1:0]                  sroot;
  logic [$bits(sqrt_side_t)-1:0]  sside_raw;
  sqrt_side_t                     sside;

  qrs_sqrt #(
    .SW  (SW),
    .SBW ($bits(sqrt_side_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .rad_i   (rad5_q),
    .side_i  (ss5_q),
    .valid_o (sv),
    .root_o  (sroot),
    .side_o  (sside_raw)
  );

  assign sside = sside_raw;

  // ---------------------------------------------------------------- numerators, divisor
  logic                  v6_q;
  logic signed [SNW-1:0] s6, bx6, num0_d, num1_d, den6_d;
  logic signed [SNW-1:0] num0_q, num1_q, den6_q;
  qrs_pkg::root_count_e  cnt6_q;

  always_comb begin
    s6  = $signed({1'b0, sroot});
    bx6 = SNW'(sside.bn);
    if (sside.lin) begin
      num0_d = -SNW'(sside.cn);
      num1_d = -SNW'(sside.cn);
      den6_d = bx6;
    end else begin
      num0_d = -bx6 - s6;
      num1_d = -bx6 + s6;
      den6_d = SNW'(sside.an) <<< 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= sv;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num0_q <= num0_d;
      num1_q <= num1_d;
      den6_q <= den6_d;
      cnt6_q <= sside.count;
    end
  end

  // ---------------------------------------------------------------- divider setup, overflow
  logic                  v7_q;
  logic [RDW-1:0]        magden7;
  logic [1:0][SNW-1:0]   num7;
  logic [1:0][SNW-1:0]   absn7;
  logic [1:0][XW-1:0]    wide7;
  logic [1:0][CW-1:0]    top7;
  div_side_t             ds7_d, ds7_q;
  logic [RDW-1:0]        d7_q;
  logic [1:0][RDW-1:0]   r07_d, r07_q;
  logic [1:0][31:0]      feed7_d, feed7_q;

  always_comb begin
    num7[0]     = num0_q;
    num7[1]     = num1_q;
    magden7     = den6_q[SNW-1] ? RDW'(-den6_q) : RDW'(den6_q);
    ds7_d.count = cnt6_q;
    for (int l = 0; l < 2; l++) begin
      absn7[l]     = num7[l][SNW-1] ? SNW'(-num7[l]) : SNW'(num7[l]);
      wide7[l]     = XW'(absn7[l][RDW-1:0]) << FB;
      top7[l]      = CW'(wide7[l][XW-1:32]);
      ds7_d.ovf[l] = top7[l] >= CW'(magden7);
      ds7_d.neg[l] = num7[l][SNW-1] ^ den6_q[SNW-1];
      r07_d[l]     = ds7_d.ovf[l] ? '0 : top7[l][RDW-1:0];
      feed7_d[l]   = wide7[l][31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (en) v7_q <= v6_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d7_q    <= magden7;
      r07_q   <= r07_d;
      feed7_q <= feed7_d;
      ds7_q   <= ds7_d;
    end
  end

  // ---------------------------------------------------------------- root division
  logic                          rv;
  logic [1:0][31:0]              rquo;
  logic [1:0]                    rrnd;
  logic [$bits(div_side_t)-1:0]  rside_raw;
  div_side_t                     rside;

  qrs_div #(
    .LANES (2),
    .DW    (RDW),
    .QB    (32),
    .SBW   ($bits(div_side_t))
  ) u_root_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .div_i   (d7_q),
    .rem_i   (r07_q),
    .feed_i  (feed7_q),
    .side_i  (ds7_q),
    .valid_o (rv),
    .quo_o   (rquo),
    .rnd_o   (rrnd),
    .side_o  (rside_raw)
  );

  assign rside = rside_raw;

  // ---------------------------------------------------------------- round, saturate, output
  logic [1:0][32:0] qr8, lim8, val8;
  logic [1:0][31:0] root8;
  logic [1:0]       sat8;
  logic [1:0]       cnt_out_q;
  logic [31:0]      r0_out_q, r1_out_q;
  logic             sat_out_q;
  logic [31:0]      r0_d, r1_d;
  logic             sat_d;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qr8[l]   = {1'b0, rquo[l]} + 33'(rrnd[l]);
      lim8[l]  = rside.neg[l] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      sat8[l]  = rside.ovf[l] || (qr8[l] > lim8[l]);
      val8[l]  = sat8[l] ? lim8[l] : qr8[l];
      root8[l] = rside.neg[l] ? (~val8[l][31:0] + 32'd1) : val8[l][31:0];
    end
    unique case (rside.count)
      qrs_pkg::ROOTS_ONE: begin
        r0_d  = root8[0];
        r1_d  = 32'd0;
        sat_d = sat8[0];
      end
      qrs_pkg::ROOTS_TWO: begin
        r0_d  = root8[0];
        r1_d  = root8[1];
        sat_d = sat8[0] || sat8[1];
      end
      default: begin
        r0_d  = 32'd0;
        r1_d  = 32'd0;
        sat_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= rv;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cnt_out_q <= rside.count;
      r0_out_q  <= r0_d;
      r1_out_q  <= r1_d;
      sat_out_q <= sat_d;
    end
  end

  assign res_o.valid          = out_v_q;
  assign res_o.root_count     = cnt_out_q;
  assign res_o.first_root     = r0_out_q;
  assign res_o.second_root    = r1_out_q;
  assign res_o.root_saturated = sat_out_q;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int LATENCY = 104;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [1:0]         count;
    logic signed [31:0] r1;
    logic signed [31:0] r2;
    logic               sat;
  } roots_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel_i = 1'b0, penable_i = 1'b0, pwrite_i = 1'b0;
  logic [qrs_pkg::ADDR_W-1:0] paddr_i = '0;
  logic [31:0] pwdata_i = '0;
  logic [31:0] prdata_o;
  logic pready_o;

  qrs_req_if req_if ();
  qrs_res_if res_if ();

  quadratic_root_solver_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if.sink), .res_o(res_if.source),
    .psel_i(psel_i), .penable_i(penable_i), .pwrite_i(pwrite_i), .paddr_i(paddr_i),
    .pwdata_i(pwdata_i), .prdata_o(prdata_o), .pready_o(pready_o)
  );

  // Shadow of the epsilon register
  logic [63:0] eps;
  roots_t expected_roots[$];
  int mismatches = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;
  int hold_cycles = 0;

  initial begin
    req_if.valid = 1'b0;
    req_if.quad_coef = '0;
    req_if.lin_coef = '0;
    req_if.const_coef = '0;
    res_if.ready = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Cycle count and timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint norm_coef(longint x, logic [63:0] m);
    logic [63:0] q;
    q = ((mag(x) << 30) * 2 + m) / (2 * m);
    return x < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic bit is_tiny(longint v);
    return v == 0 || mag(v) < eps;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] root_div(longint num, longint den, ref logic sat);
    logic [63:0] n, d, q, lim;
    bit neg;
    n = mag(num) << 16;
    d = mag(den);
    q = (2 * n + d) / (2 * d);
    neg = (num < 0) != (den < 0);
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    if (neg) q = -q;
    return q[31:0];
  endfunction

  function automatic roots_t solve_roots(logic signed [31:0] qa, logic signed [31:0] qb,
                                         logic signed [31:0] qc);
    roots_t o;
    longint a, b, c, an, bn, cn, d, s;
    logic [63:0] m;
    logic sat;
    a = qa; b = qb; c = qc;
    sat = 1'b0;
    o = '0;
    m = mag(a);
    if (mag(b) > m) m = mag(b);
    if (mag(c) > m) m = mag(c);
    if (m == 0) begin
      o.count = qrs_pkg::ROOTS_ANY;
    end else begin
      an = norm_coef(a, m); bn = norm_coef(b, m); cn = norm_coef(c, m);
      if (is_tiny(an)) begin
        if (is_tiny(bn)) begin
          o.count = is_tiny(cn) ? qrs_pkg::ROOTS_ANY : qrs_pkg::ROOTS_NONE;
        end else begin
          o.count = qrs_pkg::ROOTS_ONE;
          o.r1 = root_div(-cn, bn, sat);
        end
      end else begin
        d = bn * bn - 4 * an * cn;
        if (d == 0 || mag(d) < (eps << 30)) begin
          o.count = qrs_pkg::ROOTS_ONE;
          o.r1 = root_div(-bn, 2 * an, sat);
        end else if (d > 0) begin
          s = int_sqrt(d);
          o.count = qrs_pkg::ROOTS_TWO;
          o.r1 = root_div(-bn - s, 2 * an, sat);
          o.r2 = root_div(-bn + s, 2 * an, sat);
        end else begin
          o.count = qrs_pkg::ROOTS_NONE;
        end
      end
    end
    o.sat = sat;
    return o;
  endfunction

  // Receiver: random stalls with periodic always-ready windows, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off) begin
      res_if.ready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles >= 400) begin
        hold_off <= 1'b0;
        hold_cycles <= 0;
      end
    end else if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= (cycles[9:8] == 2'b01) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // Compare each result against the oldest expectation
  always @(posedge clk_i) begin
    roots_t got, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = {res_if.root_count, res_if.first_root, res_if.second_root,
             res_if.root_saturated};
      if (expected_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_roots.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp cnt=%0d r1=%h r2=%h sat=%b got cnt=%0d r1=%h r2=%h sat=%b",
                     want.count, want.r1, want.r2, want.sat,
                     got.count, got.r1, got.r2, got.sat);
        end
      end
    end
  end

  task automatic send_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    req_if.valid <= 1'b1;
    req_if.quad_coef <= a;
    req_if.lin_coef <= b;
    req_if.const_coef <= c;
    expected_roots.push_back(solve_roots(a, b, c));
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    idle_gap(1);
    while (expected_roots.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_eps(logic [31:0] v);
    psel_i <= 1'b1; penable_i <= 1'b0; pwrite_i <= 1'b1;
    paddr_i <= {qrs_pkg::REG_NEAR_ZERO_LIMIT, 2'b00}; pwdata_i <= v;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    psel_i <= 1'b0; penable_i <= 1'b0; pwrite_i <= 1'b0;
    eps = v & 32'h7FFF_FFFF;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 200) - 100;
      2: return ($urandom_range(0, 40) - 20) << 16;
      3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      4: return 32'(signed'($urandom()) >>> $urandom_range(0, 31));
      default: return 32'(($urandom_range(0, 8) - 4)) << $urandom_range(8, 24);
    endcase
  endfunction

  task automatic test_directed();
    send_coefs(0, 0, 0);
    send_coefs(0, 0, 32'h0001_0000);
    send_coefs(0, 1, 0);
    send_coefs(0, 32'h0002_0000, 32'hFFFC_0000);
    send_coefs(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);
    send_coefs(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    send_coefs(32'h0001_0000, 0, 32'h0001_0000);
    send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_coefs(1, 32'h7FFF_FFFF, 32'h8000_0000);
    send_coefs(1, 32'h8000_0000, 32'h7FFF_FFFF);
    send_coefs(32'hFFFF_FFFF, 0, 32'h7FFF_FFFF);
    send_coefs(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    send_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_coefs(32'h0001_0000, 32'h7FFF_0000, 32'h0000_0001);
    send_coefs(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    drain();
  endtask

  task automatic test_random(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && n > 0) begin
        send_coefs(rand_coef(), rand_coef(), rand_coef());
        burst--; n--;
      end
      idle_gap($urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0);
    end
    drain();
  endtask

  // Hold the receiver off while the sender keeps offering
  task automatic test_backpressure();
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (150) send_coefs(rand_coef(), rand_coef(), rand_coef());
    drain();
  endtask

  task automatic test_eps_settings();
    write_eps(0);
    test_random(200);
    write_eps(32'h4000_0000);
    test_random(150);
    write_eps(32'h7FFF_FFFF);
    test_random(50);
    write_eps(32'd1 << $urandom_range(10, 29));
    test_random(150);
    write_eps(qrs_pkg::EPS_RESET);
  endtask

  initial begin
    eps = qrs_pkg::EPS_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1000);
    test_backpressure();
    test_eps_settings();
    if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
